// File: src/htg_pkg.sv
`timescale 1ns / 1ps

package htg_pkg;

	localparam int TEMP_W  = 12;
	localparam int BAND_W  = 10;
	localparam int COUNT_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	// thresholds are target +/- band, kept exact
	localparam int THR_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_BAND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ON_MINUTES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REST_MINUTES    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MINUTES = 3'd4;

	// 22.0 degrees and 1.5 degrees in sixteenths
	localparam logic signed [TEMP_W-1:0] TARGET_RESET = 12'sd352;
	localparam logic [BAND_W-1:0]        BAND_RESET   = 10'd24;
	localparam logic [COUNT_W-1:0]       MAX_ON_RESET = 8'd30;
	localparam logic [COUNT_W-1:0]       REST_RESET   = 8'd5;
	localparam logic [COUNT_W-1:0]       TIMEOUT_RESET = 8'd5;
	localparam logic [COUNT_W-1:0]       COUNT_MAX    = 8'd255;

	typedef struct packed {
		logic heater_drive;
		logic alarm_active;
		logic alarm_raised;
		logic sensor_recovered;
	} result_t;

endpackage

// File: src/htg_if.sv
`timescale 1ns / 1ps

interface htg_in_if
	import htg_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     sample_valid;
	logic signed [TEMP_W-1:0] temperature;

	modport source (output valid, output sample_valid, output temperature, input ready);
	modport sink (input valid, input sample_valid, input temperature, output ready);
endinterface

interface htg_out_if
	import htg_pkg::*;
();
	logic valid;
	logic ready;
	logic heater_drive;
	logic alarm_active;
	logic alarm_raised;
	logic sensor_recovered;

	modport source (output valid, output heater_drive, output alarm_active,
		output alarm_raised, output sensor_recovered, input ready);
	modport sink (input valid, input heater_drive, input alarm_active,
		input alarm_raised, input sensor_recovered, output ready);
endinterface

interface htg_cfg_if
	import htg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/heater_thermostat_guard_top.sv
`timescale 1ns / 1ps
// a request is registered in stage 1 at acceptance, and its result then in the stage 2 result register
// throughput: one request per cycle; the state update is one short compare/count stage
// input stalls only while a result waits in the output register and stage 1 is also full
// reset (arst_n low, asynchronous): heater off, counters zero, alarm clear,
// configuration back to 22.0 deg target, 1.5 deg band, 30 on, 5 rest, 5 timeout

module heater_thermostat_guard_top
	import htg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	htg_in_if.sink    sample,
	htg_out_if.source result,
	htg_cfg_if.sink   cfg
);

	// configuration registers
	logic signed [TEMP_W-1:0] target_q;
	logic [BAND_W-1:0]        band_q;
	logic [COUNT_W-1:0]       max_on_q;
	logic [COUNT_W-1:0]       rest_len_q;
	logic [COUNT_W-1:0]       timeout_q;

	// controller state
	logic               heater_q;
	logic               alarm_q;
	logic [COUNT_W-1:0] on_run_q;
	logic [COUNT_W-1:0] rest_q;
	logic [COUNT_W-1:0] silent_q;

	// stage 1: accepted request
	logic                     valid_s1;
	logic                     smp_valid_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	// stage 2: result register
	logic    valid_s2;
	result_t res_s2;

	logic advance;
	logic take_in;

	// next-state logic
	logic               heater_d;
	logic               alarm_d;
	logic [COUNT_W-1:0] on_run_d;
	logic [COUNT_W-1:0] rest_d;
	logic [COUNT_W-1:0] silent_d;
	logic               raised_d;
	logic               recovered_d;

	logic [COUNT_W-1:0]      silent_inc;
	logic [COUNT_W-1:0]      on_inc;
	logic signed [THR_W-1:0] temp_w;
	logic signed [THR_W-1:0] thr_on;
	logic signed [THR_W-1:0] thr_off;

	// config channel is always open; writes must come only while idle (the block does not enforce this)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= TARGET_RESET;
			band_q     <= BAND_RESET;
			max_on_q   <= MAX_ON_RESET;
			rest_len_q <= REST_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TARGET_TEMP:     target_q   <= cfg.data[TEMP_W-1:0];
				REG_HYSTERESIS_BAND: band_q     <= cfg.data[BAND_W-1:0];
				REG_MAX_ON_MINUTES:  max_on_q   <= cfg.data[COUNT_W-1:0];
				REG_REST_MINUTES:    rest_len_q <= cfg.data[COUNT_W-1:0];
				REG_TIMEOUT_MINUTES: timeout_q  <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take_in      = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			smp_valid_s1 <= sample.sample_valid;
			temp_s1      <= sample.temperature;
		end
	end

	// exact thresholds in 14-bit signed arithmetic
	assign temp_w  = THR_W'(temp_s1);
	assign thr_on  = THR_W'(target_q) - $signed({{(THR_W-BAND_W){1'b0}}, band_q});
	assign thr_off = THR_W'(target_q) + $signed({{(THR_W-BAND_W){1'b0}}, band_q});

	// saturating increments
	assign silent_inc = (silent_q != COUNT_MAX) ? silent_q + 1'b1 : silent_q;
	assign on_inc     = (on_run_q != COUNT_MAX) ? on_run_q + 1'b1 : on_run_q;

	always_comb begin
		heater_d    = heater_q;
		alarm_d     = alarm_q;
		on_run_d    = on_run_q;
		rest_d      = rest_q;
		silent_d    = silent_q;
		raised_d    = 1'b0;
		recovered_d = 1'b0;
		if (!smp_valid_s1) begin
			// silent tick: count up, trip the watchdog at the timeout
			silent_d = silent_inc;
			if (silent_inc >= timeout_q) begin
				raised_d = heater_q || !alarm_q;
				heater_d = 1'b0;
				alarm_d  = 1'b1;
			end
		end else begin
			// good sample clears the watchdog
			recovered_d = (silent_q >= timeout_q);
			silent_d    = '0;
			alarm_d     = 1'b0;
			if (rest_q != '0) begin
				// forced rest in progress
				rest_d   = rest_q - 1'b1;
				heater_d = 1'b0;
			end else if (heater_q) begin
				on_run_d = on_inc;
				if (on_inc >= max_on_q) begin
					// run limit hit: start the rest period
					heater_d = 1'b0;
					rest_d   = rest_len_q;
					on_run_d = '0;
				end else if (temp_w >= thr_off) begin
					heater_d = 1'b0;
					on_run_d = '0;
				end
			end else if (temp_w <= thr_on) begin
				heater_d = 1'b1;
				on_run_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= 1'b0;
			alarm_q  <= 1'b0;
			on_run_q <= '0;
			rest_q   <= '0;
			silent_q <= '0;
		end else if (advance) begin
			heater_q <= heater_d;
			alarm_q  <= alarm_d;
			on_run_q <= on_run_d;
			rest_q   <= rest_d;
			silent_q <= silent_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.heater_drive     <= heater_d;
			res_s2.alarm_active     <= alarm_d;
			res_s2.alarm_raised     <= raised_d;
			res_s2.sensor_recovered <= recovered_d;
		end
	end

	assign result.valid            = valid_s2;
	assign result.heater_drive     = res_s2.heater_drive;
	assign result.alarm_active     = res_s2.alarm_active;
	assign result.alarm_raised     = res_s2.alarm_raised;
	assign result.sensor_recovered = res_s2.sensor_recovered;

	// the watchdog always holds the heater off
	a_alarm_heater_off: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q |-> !heater_q)
		else $error("heater on while alarm is set");

	// no heating during a forced rest
	a_rest_heater_off: assert property (@(posedge clk) disable iff (!arst_n)
		(rest_q != '0) |-> !heater_q)
		else $error("heater on during forced rest");

	// raise and recovery pulses never come from the same request
	a_pulse_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.alarm_raised && res_s2.sensor_recovered))
		else $error("raise and recovery pulses together");

	// a raise pulse comes with the alarm set and the heater off
	a_raise_sets_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.alarm_raised) |-> (res_s2.alarm_active && !res_s2.heater_drive))
		else $error("raise pulse without alarm");

endmodule
